### rtl/core/lhp_pkg.sv
// Shared types, constants and the control-store program of the duration
// statistics monitor. No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lhp_pkg;

	// Datapath operations, one per control word
	typedef enum logic [3:0] {
		OP_NOP,
		OP_CLR,
		OP_IDLE,
		OP_REC,
		OP_DIV,
		OP_RMW_RD,
		OP_RMW_WR,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_MUL_ADD,
		OP_WALK_RD,
		OP_WALK_SC,
		OP_WALK_CMP
	} dp_op_t;

	// Branch conditions of the sequencer
	typedef enum logic [3:0] {
		C_NEXT,
		C_JUMP,
		C_IF_NO_START,
		C_IF_NOT_LAST,
		C_IF_QUERY,
		C_IF_OVER,
		C_IF_EMPTY,
		C_IF_MISS
	} cond_t;

	typedef logic [3:0] upc_t;

	typedef struct packed {
		dp_op_t op;
		cond_t  cond;
		upc_t   tgt;
		logic   done;
		logic   idle;
	} cw_t;

	// Flags the datapath hands back for conditional jumps
	typedef struct packed {
		logic is_query;
		logic over;
		logic empty;
		logic miss;
		logic not_last;
	} dp_stat_t;

	// Program addresses
	localparam upc_t STEP_CLR      = 4'd0;
	localparam upc_t STEP_IDLE     = 4'd1;
	localparam upc_t STEP_DISP     = 4'd2;
	localparam upc_t STEP_REC      = 4'd3;
	localparam upc_t STEP_DIV      = 4'd4;
	localparam upc_t STEP_RMW_RD   = 4'd5;
	localparam upc_t STEP_RMW_WR   = 4'd6;
	localparam upc_t STEP_MUL_LO   = 4'd7;
	localparam upc_t STEP_MUL_HI   = 4'd8;
	localparam upc_t STEP_MUL_ADD  = 4'd9;
	localparam upc_t STEP_WALK_RD  = 4'd10;
	localparam upc_t STEP_WALK_SC  = 4'd11;
	localparam upc_t STEP_WALK_CMP = 4'd12;
	localparam upc_t STEP_FIN      = 4'd13;

	localparam logic MODE_QUERY = 1'b1;

	// Ranks are in thousandths
	localparam logic [9:0] PER_MILLE = 10'd1000;

	localparam logic [31:0] BIN_FULL = 32'hFFFF_FFFF;

	// Control store
	function automatic cw_t ucode(input upc_t pc);
		cw_t w;
		w = '{op: OP_NOP, cond: C_JUMP, tgt: STEP_IDLE, done: 1'b0, idle: 1'b0};
		case (pc)
			STEP_CLR:      w = '{OP_CLR,      C_IF_NOT_LAST, STEP_CLR,      1'b0, 1'b0};
			STEP_IDLE:     w = '{OP_IDLE,     C_IF_NO_START, STEP_IDLE,     1'b0, 1'b1};
			STEP_DISP:     w = '{OP_NOP,      C_IF_QUERY,    STEP_MUL_LO,   1'b0, 1'b0};
			STEP_REC:      w = '{OP_REC,      C_IF_OVER,     STEP_RMW_RD,   1'b0, 1'b0};
			STEP_DIV:      w = '{OP_DIV,      C_NEXT,        STEP_IDLE,     1'b0, 1'b0};
			STEP_RMW_RD:   w = '{OP_RMW_RD,   C_NEXT,        STEP_IDLE,     1'b0, 1'b0};
			STEP_RMW_WR:   w = '{OP_RMW_WR,   C_JUMP,        STEP_FIN,      1'b0, 1'b0};
			STEP_MUL_LO:   w = '{OP_MUL_LO,   C_IF_EMPTY,    STEP_FIN,      1'b0, 1'b0};
			STEP_MUL_HI:   w = '{OP_MUL_HI,   C_NEXT,        STEP_IDLE,     1'b0, 1'b0};
			STEP_MUL_ADD:  w = '{OP_MUL_ADD,  C_NEXT,        STEP_IDLE,     1'b0, 1'b0};
			STEP_WALK_RD:  w = '{OP_WALK_RD,  C_NEXT,        STEP_IDLE,     1'b0, 1'b0};
			STEP_WALK_SC:  w = '{OP_WALK_SC,  C_NEXT,        STEP_IDLE,     1'b0, 1'b0};
			STEP_WALK_CMP: w = '{OP_WALK_CMP, C_IF_MISS,     STEP_WALK_RD,  1'b0, 1'b0};
			STEP_FIN:      w = '{OP_NOP,      C_JUMP,        STEP_IDLE,     1'b1, 1'b0};
			default:       w = '{OP_NOP,      C_JUMP,        STEP_IDLE,     1'b0, 1'b0};
		endcase
		return w;
	endfunction

endpackage

### rtl/core/latency_histogram_percentile_top.sv
// Record: dispatch, record, bin index multiply, bin read and write, then done;
// durations beyond the table skip the bin multiply step.
// Query: dispatch, rank multiply (low, high, add), then read, scale and compare
// for each bin walked, then done; an empty monitor answers after the low multiply.
// One item at a time; done pulses one cycle, the receiver cannot stall.
// Reset clears statistics, then a pass zeroes the bins one by one (busy high).
// Depends on lhp_pkg, lhp_seq, lhp_dp.
`timescale 1ns / 1ps

module latency_histogram_percentile_top #(
	parameter int NUM_BINS = 64,
	parameter int BIN_NS   = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [63:0] duration_ns,
	input  logic [9:0]  per_thousand,
	output logic        done,
	output logic [31:0] percentile_ns,
	output logic [63:0] total_ns,
	output logic [63:0] max_ns,
	output logic [63:0] event_count
);

	lhp_pkg::cw_t      cw;
	lhp_pkg::dp_stat_t stat;

	// Control sequencer
	lhp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cw     (cw),
		.busy   (busy),
		.done   (done)
	);

	// Datapath and bin memory
	lhp_dp #(
		.NUM_BINS (NUM_BINS),
		.BIN_NS   (BIN_NS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (cw.op),
		.start         (start),
		.mode          (mode),
		.duration_ns   (duration_ns),
		.per_thousand  (per_thousand),
		.stat          (stat),
		.percentile_ns (percentile_ns),
		.total_ns      (total_ns),
		.max_ns        (max_ns),
		.event_count   (event_count)
	);

endmodule

### rtl/core/lhp_seq.sv
// Microcode sequencer: step counter, control-store lookup and branch logic.
// Depends on lhp_pkg (control word, conditions, program addresses).
`timescale 1ns / 1ps

module lhp_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lhp_pkg::dp_stat_t stat,
	output lhp_pkg::cw_t      cw,
	output logic              busy,
	output logic              done
);

	lhp_pkg::upc_t upc_q;
	lhp_pkg::upc_t upc_d;
	logic          take;

	// Current control word
	always_comb begin
		cw = lhp_pkg::ucode(upc_q);
	end

	assign busy = ~cw.idle;
	assign done = cw.done;

	// Branch condition select
	always_comb begin
		case (cw.cond)
			lhp_pkg::C_NEXT:        take = 1'b0;
			lhp_pkg::C_JUMP:        take = 1'b1;
			lhp_pkg::C_IF_NO_START: take = ~start;
			lhp_pkg::C_IF_NOT_LAST: take = stat.not_last;
			lhp_pkg::C_IF_QUERY:    take = stat.is_query;
			lhp_pkg::C_IF_OVER:     take = stat.over;
			lhp_pkg::C_IF_EMPTY:    take = stat.empty;
			lhp_pkg::C_IF_MISS:     take = stat.miss;
			default:                take = 1'b1;
		endcase
		upc_d = take ? cw.tgt : lhp_pkg::upc_t'(upc_q + 4'd1);
	end

	// Step counter; reset enters the bin clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= lhp_pkg::STEP_CLR;
		end else begin
			upc_q <= upc_d;
		end
	end

	// An accepted beat always goes to dispatch
	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (upc_q == lhp_pkg::STEP_DISP))
		else $error("accepted beat did not reach dispatch");

	// After a result the block is ready again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block not ready after result");

endmodule

### rtl/core/lhp_dp.sv
// Datapath: input latch, running statistics, bin index reciprocal multiply,
// shared 32x10 multiplier, percentile walk and the bin count memory.
// Depends on lhp_pkg; driven by lhp_seq control words.
`timescale 1ns / 1ps

module lhp_dp #(
	parameter int NUM_BINS = 64,
	parameter int BIN_NS   = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lhp_pkg::dp_op_t   op,
	input  logic              start,
	input  logic              mode,
	input  logic [63:0]       duration_ns,
	input  logic [9:0]        per_thousand,
	output lhp_pkg::dp_stat_t stat,
	output logic [31:0]       percentile_ns,
	output logic [63:0]       total_ns,
	output logic [63:0]       max_ns,
	output logic [63:0]       event_count
);

	localparam int          AW        = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam logic [AW-1:0] LAST    = AW'(NUM_BINS - 1);
	localparam logic [63:0] LIMIT     = 64'(NUM_BINS) * 64'(BIN_NS);
	localparam int          DW        = $clog2(LIMIT);
	localparam int          LB        = $clog2(BIN_NS);
	localparam int          SH        = DW + LB;
	// ceil(2^SH / BIN_NS): exact floor division for any DW-bit dividend
	localparam logic [DW:0] RECIP     =
		(DW+1)'(((64'd1 << SH) + 64'(BIN_NS) - 64'd1) / 64'(BIN_NS));
	localparam logic [31:0] BIN_STEP  = 32'(BIN_NS);

	// Latched input beat
	logic        mode_q;
	logic [63:0] dur_q;
	logic [9:0]  k_q;

	// Running statistics
	logic [63:0] sum_q;
	logic [63:0] peak_q;
	logic [63:0] event_q;

	// Sequencing and result
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] quo_q;
	logic [31:0]   bstart_q;
	logic [31:0]   res_q;

	// Arithmetic work registers
	logic [41:0]   mul_q;
	logic [73:0]   rem_q;
	logic [31:0]   rdata_q;

	logic [31:0] bins_mem [NUM_BINS];

	logic [31:0]   mul_a;
	logic [9:0]    mul_b;
	logic [41:0]   mul_p;
	logic [2*DW:0] quo_p;
	logic          hit;
	logic [AW-1:0] mem_addr;
	logic          mem_we;
	logic          mem_re;
	logic [31:0]   mem_wdata;

	// Shared multiplier operand select
	always_comb begin
		case (op)
			lhp_pkg::OP_MUL_LO: begin
				mul_a = event_q[31:0];
				mul_b = k_q;
			end
			lhp_pkg::OP_MUL_HI: begin
				mul_a = event_q[63:32];
				mul_b = k_q;
			end
			default: begin
				mul_a = rdata_q;
				mul_b = lhp_pkg::PER_MILLE;
			end
		endcase
		mul_p = 42'(mul_a) * 42'(mul_b);
	end

	// Bin index of an in-table duration by reciprocal multiply
	assign quo_p = (2*DW+1)'(dur_q[DW-1:0]) * (2*DW+1)'(RECIP);

	// Walk hit test
	assign hit    = (74'(mul_q) >= rem_q) || (cnt_q == LAST);

	assign stat.is_query = (mode_q == lhp_pkg::MODE_QUERY);
	assign stat.over     = (dur_q >= LIMIT);
	assign stat.empty    = (event_q == 64'd0);
	assign stat.miss     = ~hit;
	assign stat.not_last = (cnt_q != LAST);

	// Memory port control
	always_comb begin
		mem_addr  = cnt_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = '0;
		case (op)
			lhp_pkg::OP_CLR: begin
				mem_we = 1'b1;
			end
			lhp_pkg::OP_RMW_RD: begin
				mem_addr = quo_q;
				mem_re   = 1'b1;
			end
			lhp_pkg::OP_RMW_WR: begin
				mem_addr  = quo_q;
				mem_we    = 1'b1;
				// saturating increment
				mem_wdata = (rdata_q == lhp_pkg::BIN_FULL) ? rdata_q : rdata_q + 32'd1;
			end
			lhp_pkg::OP_WALK_RD: begin
				mem_re = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Bin count memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bins_mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= bins_mem[mem_addr];
		end
	end

	// Work registers (no reset)
	always_ff @(posedge clk) begin
		case (op)
			lhp_pkg::OP_IDLE: begin
				if (start) begin
					mode_q <= mode;
					dur_q  <= duration_ns;
					k_q    <= per_thousand;
				end
			end
			lhp_pkg::OP_MUL_LO: begin
				mul_q <= mul_p;
			end
			lhp_pkg::OP_MUL_HI: begin
				rem_q <= 74'(mul_q);
				mul_q <= mul_p;
			end
			lhp_pkg::OP_MUL_ADD: begin
				rem_q <= rem_q + {mul_q, 32'd0};
			end
			lhp_pkg::OP_WALK_SC: begin
				mul_q <= mul_p;
			end
			lhp_pkg::OP_WALK_CMP: begin
				if (!hit) begin
					rem_q <= rem_q - 74'(mul_q);
				end
			end
			default: begin
				mul_q <= mul_q;
			end
		endcase
	end

	// Control and statistics registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			peak_q   <= '0;
			event_q  <= '0;
			cnt_q    <= '0;
			quo_q    <= '0;
			bstart_q <= '0;
			res_q    <= '0;
		end else begin
			case (op)
				lhp_pkg::OP_CLR: begin
					cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + AW'(1);
				end
				lhp_pkg::OP_REC: begin
					sum_q   <= sum_q + dur_q;
					event_q <= event_q + 64'd1;
					if (dur_q > peak_q) begin
						peak_q <= dur_q;
					end
					res_q <= '0;
					quo_q <= stat.over ? LAST : '0;
				end
				lhp_pkg::OP_DIV: begin
					quo_q <= AW'(quo_p >> SH);
				end
				lhp_pkg::OP_MUL_LO: begin
					res_q    <= '0;
					cnt_q    <= '0;
					bstart_q <= '0;
				end
				lhp_pkg::OP_WALK_CMP: begin
					if (hit) begin
						res_q <= bstart_q;
					end else begin
						cnt_q    <= cnt_q + AW'(1);
						bstart_q <= bstart_q + BIN_STEP;
					end
				end
				default: begin
					res_q <= res_q;
				end
			endcase
		end
	end

	assign percentile_ns = res_q;
	assign total_ns      = sum_q;
	assign max_ns        = peak_q;
	assign event_count   = event_q;

	// Bin index never leaves the table
	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		(op == lhp_pkg::OP_RMW_RD) |-> (quo_q <= LAST))
		else $error("bin index out of range");

	// A hit latches the current bin start
	a_walk_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(op == lhp_pkg::OP_WALK_CMP && hit) |=> (res_q == $past(bstart_q)))
		else $error("percentile not taken from hit bin");

endmodule
